// ===== design/afac_pkg.sv =====
`timescale 1ns / 1ps

package afac_pkg;

  // Sizing defaults
  localparam int MAX_FRAME_DEF   = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 3'd0,
    CFG_JUMP  = 3'd1,
    CFG_CURVE = 3'd2,
    CFG_LOUD  = 3'd3,
    CFG_PEAK  = 3'd4
  } cfg_index_t;

  // Register reset values
  localparam logic        MODE_RST  = 1'b1;
  localparam logic [15:0] JUMP_RST  = 16'd15000;
  localparam logic [16:0] CURVE_RST = 17'd10000;
  localparam logic [15:0] LOUD_RST  = 16'd20000;
  localparam logic [15:0] PEAK_RST  = 16'd29492;

  // Minimum frame lengths
  localparam int HEUR_MIN  = 64;
  localparam int BASIC_MIN = 32;

  // Result codes
  localparam logic [2:0] LEVEL_NONE     = 3'd0;
  localparam logic [2:0] LEVEL_AMBIENT  = 3'd1;
  localparam logic [2:0] LEVEL_TARGETED = 3'd2;
  localparam logic [2:0] LEVEL_ACTIVE   = 3'd3;
  localparam logic [2:0] LEVEL_HOSTILE  = 3'd4;

  localparam logic [1:0] KIND_NONE      = 2'd0;
  localparam logic [1:0] KIND_BEACON    = 2'd1;
  localparam logic [1:0] KIND_LASER     = 2'd2;
  localparam logic [1:0] KIND_RECORDING = 2'd3;

  localparam logic [6:0] CONF_NONE      = 7'd0;
  localparam logic [6:0] CONF_BEACON    = 7'd80;
  localparam logic [6:0] CONF_LASER     = 7'd90;
  localparam logic [6:0] CONF_RECORDING = 7'd60;
  localparam logic [6:0] CONF_BASIC     = 7'd40;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_in_frame;
  } in_word_t;

  typedef struct packed {
    logic [2:0] alert_level;
    logic [1:0] threat_kind;
    logic [6:0] confidence_pct;
    logic       frame_short;
    logic       frame_overflow;
  } out_word_t;

  typedef struct packed {
    logic        analysis_mode;
    logic [15:0] jump_threshold;
    logic [16:0] curvature_threshold;
    logic [15:0] loud_threshold;
    logic [15:0] peak_threshold;
  } cfg_t;

  // Per-sample features passed from front to back
  typedef struct packed {
    logic        counted;  // 0 when the sample lies past the frame limit
    logic        jump;
    logic        curve;
    logic        loud;
    logic        zero;
    logic [15:0] mag;
    logic        last;
  } feat_t;

endpackage

// ===== design/afac_front.sv =====
`timescale 1ns / 1ps

module afac_front #(
  parameter int MAX_FRAME = afac_pkg::MAX_FRAME_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  afac_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_stall,
  input  afac_pkg::in_word_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output afac_pkg::feat_t  q_data
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [CW-1:0]      count;
  logic signed [15:0] prev;
  logic signed [15:0] older;

  logic               accept;
  logic               counted;
  logic signed [16:0] s17;
  logic signed [16:0] d1;
  logic [16:0]        mag1;
  logic signed [18:0] d2;
  logic [18:0]        mag2;
  logic signed [16:0] mag17;

  assign in_stall = q_full;
  assign accept   = in_valid & ~q_full;
  assign q_push   = accept;

  // Feature extraction on the incoming word
  always_comb begin
    counted = (count < CW'(MAX_FRAME));
    s17     = {in_data.sample[15], in_data.sample};
    d1      = s17 - {prev[15], prev};
    mag1    = d1[16] ? 17'(-d1) : 17'(d1);
    d2      = {{3{in_data.sample[15]}}, in_data.sample}
            - {{2{prev[15]}}, prev, 1'b0}
            + {{3{older[15]}}, older};
    mag2    = d2[18] ? 19'(-d2) : 19'(d2);
    mag17   = s17[16] ? -s17 : s17;

    q_data.counted = counted;
    q_data.jump    = counted && (count != '0) && (mag1 > {1'b0, cfg.jump_threshold});
    q_data.curve   = counted && (count > CW'(1))
                     && (mag2 > {2'b00, cfg.curvature_threshold});
    q_data.mag     = mag17[15:0];
    q_data.loud    = counted && (mag17[15:0] > cfg.loud_threshold);
    q_data.zero    = counted && (in_data.sample == 16'sd0);
    q_data.last    = in_data.last_in_frame;
  end

  // Frame position and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      prev  <= '0;
      older <= '0;
    end else if (accept) begin
      if (in_data.last_in_frame) begin
        count <= '0;
        prev  <= '0;
        older <= '0;
      end else if (counted) begin
        count <= count + CW'(1);
        prev  <= in_data.sample;
        older <= prev;
      end
    end
  end

endmodule

// ===== design/afac_queue.sv =====
`timescale 1ns / 1ps

module afac_queue #(
  parameter int DEPTH = afac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  afac_pkg::feat_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output afac_pkg::feat_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  afac_pkg::feat_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   fill;

  assign full  = (fill == NW'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// ===== design/afac_back.sv =====
`timescale 1ns / 1ps

module afac_back #(
  parameter int MAX_FRAME = afac_pkg::MAX_FRAME_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  afac_pkg::cfg_t     cfg,
  input  logic               q_empty,
  input  afac_pkg::feat_t    q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output afac_pkg::out_word_t out_data
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int SW = CW + 15;
  localparam int PW = CW + 20;

  typedef struct packed {
    logic [CW-1:0] n;
    logic [CW-1:0] jump;
    logic [CW-1:0] curve;
    logic [CW-1:0] loud;
    logic [CW-1:0] zero;
    logic [SW-1:0] sum;
    logic [15:0]   peak;
    logic          ovf;
  } stats_t;

  stats_t acc;
  stats_t acc_next;
  stats_t fin;
  logic   fin_valid;
  logic   load_out;
  logic   fin_ready;

  logic [PW-1:0] n_w, j5, c20, n3, s10, n3_big, l10, z20;
  afac_pkg::out_word_t res;

  // Accumulate one word
  always_comb begin
    acc_next       = acc;
    acc_next.ovf   = acc.ovf | ~q_head.counted;
    if (q_head.counted) begin
      acc_next.n     = acc.n + CW'(1);
      acc_next.jump  = acc.jump + CW'(q_head.jump);
      acc_next.curve = acc.curve + CW'(q_head.curve);
      acc_next.loud  = acc.loud + CW'(q_head.loud);
      acc_next.zero  = acc.zero + CW'(q_head.zero);
      acc_next.sum   = acc.sum + SW'(q_head.mag);
      if (q_head.mag > acc.peak) begin
        acc_next.peak = q_head.mag;
      end
    end
  end

  assign load_out  = fin_valid && (!out_valid || !out_stall);
  assign fin_ready = !fin_valid || load_out;
  assign q_pop     = !q_empty && (!q_head.last || fin_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      fin_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        acc <= q_head.last ? '0 : acc_next;
      end
      if (q_pop && q_head.last) begin
        fin_valid <= 1'b1;
      end else if (load_out) begin
        fin_valid <= 1'b0;
      end
    end
  end

  // Frame totals snapshot
  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      fin <= acc_next;
    end
  end

  // Ratio tests by cross-multiplication with constants
  always_comb begin
    n_w    = PW'(fin.n);
    j5     = (PW'(fin.jump) << 2) + PW'(fin.jump);
    c20    = (PW'(fin.curve) << 4) + (PW'(fin.curve) << 2);
    n3     = (n_w << 1) + n_w;
    s10    = (PW'(fin.sum) << 3) + (PW'(fin.sum) << 1);
    n3_big = n3 << 15;
    l10    = (PW'(fin.loud) << 3) + (PW'(fin.loud) << 1);
    z20    = (PW'(fin.zero) << 4) + (PW'(fin.zero) << 2);

    res.alert_level    = afac_pkg::LEVEL_NONE;
    res.threat_kind    = afac_pkg::KIND_NONE;
    res.confidence_pct = afac_pkg::CONF_NONE;
    res.frame_short    = 1'b0;
    res.frame_overflow = fin.ovf;

    if (cfg.analysis_mode) begin
      priority if (n_w < PW'(afac_pkg::HEUR_MIN)) begin
        res.frame_short = 1'b1;
      end else if (j5 > n_w) begin
        res.alert_level    = afac_pkg::LEVEL_ACTIVE;
        res.threat_kind    = afac_pkg::KIND_BEACON;
        res.confidence_pct = afac_pkg::CONF_BEACON;
      end else if (c20 > n3) begin
        res.alert_level    = afac_pkg::LEVEL_HOSTILE;
        res.threat_kind    = afac_pkg::KIND_LASER;
        res.confidence_pct = afac_pkg::CONF_LASER;
      end else if ((fin.peak >= cfg.peak_threshold) && (s10 > n3_big)) begin
        res.alert_level    = afac_pkg::LEVEL_TARGETED;
        res.threat_kind    = afac_pkg::KIND_RECORDING;
        res.confidence_pct = afac_pkg::CONF_RECORDING;
      end else begin
        res.frame_short = 1'b0;
      end
    end else begin
      priority if (n_w < PW'(afac_pkg::BASIC_MIN)) begin
        res.frame_short = 1'b1;
      end else if ((l10 > n_w) && (z20 < n_w)) begin
        res.alert_level    = afac_pkg::LEVEL_AMBIENT;
        res.threat_kind    = afac_pkg::KIND_RECORDING;
        res.confidence_pct = afac_pkg::CONF_BASIC;
      end else begin
        res.frame_short = 1'b0;
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

  // Checks
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !load_out |=> fin_valid && $stable(fin))
    else $error("frame totals lost while waiting for the output register");

  a_last_fills_fin: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_head.last |=> fin_valid)
    else $error("frame end did not produce totals");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    acc.n <= CW'(MAX_FRAME))
    else $error("sample count past frame limit");

  a_short_no_threat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_short |-> out_data.alert_level == afac_pkg::LEVEL_NONE)
    else $error("short frame carries a threat");

  a_conf_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.alert_level == afac_pkg::LEVEL_NONE)
                   == (out_data.confidence_pct == afac_pkg::CONF_NONE)))
    else $error("confidence inconsistent with threat level");

endmodule

// ===== design/audio_frame_anomaly_classifier_top.sv =====
`timescale 1ns / 1ps

// Channel | Handshake            | Word
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_stall  | in_data  : sample, last_in_frame
// out     | out_valid / out_stall| out_data : level, kind, confidence, flags
// cfg     | cfg_we               | cfg_index, cfg_data (write only)
//
// One sample word is accepted per cycle while in_stall is low; one result word
// per frame end. A result passes through the queue write, the totals snapshot
// and the output register after the last sample of its frame is accepted.
// rst is synchronous; it restores register defaults and clears all frame state.
// in_stall rises only when the QUEUE_DEPTH-entry queue between the feature
// front end and the accumulator fills, which happens only while out_stall holds.

module audio_frame_anomaly_classifier_top #(
  parameter int MAX_FRAME   = afac_pkg::MAX_FRAME_DEF,
  parameter int QUEUE_DEPTH = afac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  afac_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output afac_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [afac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afac_pkg::CFG_DATA_W-1:0] cfg_data
);

  afac_pkg::cfg_t  cfg;
  logic            q_full;
  logic            q_push;
  afac_pkg::feat_t q_in;
  logic            q_pop;
  logic            q_empty;
  afac_pkg::feat_t q_head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.analysis_mode       <= afac_pkg::MODE_RST;
      cfg.jump_threshold      <= afac_pkg::JUMP_RST;
      cfg.curvature_threshold <= afac_pkg::CURVE_RST;
      cfg.loud_threshold      <= afac_pkg::LOUD_RST;
      cfg.peak_threshold      <= afac_pkg::PEAK_RST;
    end else if (cfg_we) begin
      unique case (afac_pkg::cfg_index_t'(cfg_index))
        afac_pkg::CFG_MODE:  cfg.analysis_mode       <= cfg_data[0];
        afac_pkg::CFG_JUMP:  cfg.jump_threshold      <= cfg_data[15:0];
        afac_pkg::CFG_CURVE: cfg.curvature_threshold <= cfg_data[16:0];
        afac_pkg::CFG_LOUD:  cfg.loud_threshold      <= cfg_data[15:0];
        afac_pkg::CFG_PEAK:  cfg.peak_threshold      <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  afac_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  afac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  afac_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== verif/tb_audio_frame_anomaly_classifier_top.sv =====
`timescale 1ns / 1ps

module tb_audio_frame_anomaly_classifier_top;

  localparam int FRAME_LIMIT   = afac_pkg::MAX_FRAME_DEF;
  localparam int ITEM_TARGET   = 1850;
  localparam int RESULT_TARGET = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int IW            = afac_pkg::CFG_IDX_W;
  localparam int DW            = afac_pkg::CFG_DATA_W;

  typedef enum int {
    STYLE_NOISE,
    STYLE_BUZZ,
    STYLE_LOUD,
    STYLE_QUIET,
    STYLE_SPARSE,
    STYLE_MIX
  } frame_style_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  afac_pkg::in_word_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  afac_pkg::out_word_t out_data;
  logic                cfg_we    = 1'b0;
  logic [IW-1:0]       cfg_index = '0;
  logic [DW-1:0]       cfg_data  = '0;

  audio_frame_anomaly_classifier_top #(.MAX_FRAME(FRAME_LIMIT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Classifier copy: register file and per-frame statistics
  afac_pkg::cfg_t cur_cfg = '{analysis_mode: afac_pkg::MODE_RST,
                              jump_threshold: afac_pkg::JUMP_RST,
                              curvature_threshold: afac_pkg::CURVE_RST,
                              loud_threshold: afac_pkg::LOUD_RST,
                              peak_threshold: afac_pkg::PEAK_RST};

  logic signed [15:0] prev_smp      = '0;
  logic signed [15:0] older_smp     = '0;
  logic [12:0]        n_samples     = '0;
  logic [12:0]        n_jumps       = '0;
  logic [12:0]        n_curves      = '0;
  logic [12:0]        n_loud        = '0;
  logic [12:0]        n_zero        = '0;
  logic [27:0]        mag_total     = '0;
  logic [15:0]        mag_peak      = '0;
  logic               frame_overran = 1'b0;

  afac_pkg::in_word_t  sample_backlog[$];
  afac_pkg::out_word_t verdicts_due[$];

  int idle_pct        = 37;
  int words_sent      = 0;
  int samples_taken   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int kind_tally[4]   = '{default: 0};
  int short_tally     = 0;
  int overlong_tally  = 0;
  int basic_hits      = 0;

  // Folds one accepted sample into the frame; returns 1 with the verdict at frame end
  function automatic bit classify_sample(input afac_pkg::in_word_t w,
                                         output afac_pkg::out_word_t verdict);
    int     s;
    int     mag;
    int     d1;
    int     d2;
    longint n;
    s = int'(w.sample);
    verdict = '0;
    if (n_samples >= FRAME_LIMIT) begin
      frame_overran = 1'b1;
    end else begin
      mag = (s < 0) ? -s : s;
      d1 = s - int'(prev_smp);
      d2 = s - 2 * int'(prev_smp) + int'(older_smp);
      if (d1 < 0) d1 = -d1;
      if (d2 < 0) d2 = -d2;
      if (n_samples >= 1 && d1 > int'(cur_cfg.jump_threshold)) n_jumps++;
      if (n_samples >= 2 && d2 > int'(cur_cfg.curvature_threshold)) n_curves++;
      if (mag > int'(cur_cfg.loud_threshold)) n_loud++;
      if (s == 0) n_zero++;
      mag_total += 28'(mag);
      if (mag > int'(mag_peak)) mag_peak = 16'(mag);
      older_smp = prev_smp;
      prev_smp = w.sample;
      n_samples++;
    end
    if (!w.last_in_frame) return 1'b0;

    n = longint'(n_samples);
    verdict.frame_overflow = frame_overran;
    if (cur_cfg.analysis_mode) begin
      if (n < afac_pkg::HEUR_MIN) begin
        verdict.frame_short = 1'b1;
      end else if (longint'(n_jumps) * 5 > n) begin
        verdict.alert_level = afac_pkg::LEVEL_ACTIVE;
        verdict.threat_kind = afac_pkg::KIND_BEACON;
        verdict.confidence_pct = afac_pkg::CONF_BEACON;
      end else if (longint'(n_curves) * 20 > 3 * n) begin
        verdict.alert_level = afac_pkg::LEVEL_HOSTILE;
        verdict.threat_kind = afac_pkg::KIND_LASER;
        verdict.confidence_pct = afac_pkg::CONF_LASER;
      end else if (mag_peak >= cur_cfg.peak_threshold &&
                   longint'(mag_total) * 10 > 98304 * n) begin
        verdict.alert_level = afac_pkg::LEVEL_TARGETED;
        verdict.threat_kind = afac_pkg::KIND_RECORDING;
        verdict.confidence_pct = afac_pkg::CONF_RECORDING;
      end
    end else begin
      if (n < afac_pkg::BASIC_MIN) begin
        verdict.frame_short = 1'b1;
      end else if (longint'(n_loud) * 10 > n && longint'(n_zero) * 20 < n) begin
        verdict.alert_level = afac_pkg::LEVEL_AMBIENT;
        verdict.threat_kind = afac_pkg::KIND_RECORDING;
        verdict.confidence_pct = afac_pkg::CONF_BASIC;
      end
    end

    // statistics never carry over into the next frame
    {prev_smp, older_smp, n_samples, n_jumps, n_curves} = '0;
    {n_loud, n_zero, mag_total, mag_peak, frame_overran} = '0;
    return 1'b1;
  endfunction

  // Sample driver and random out_stall: new word or idle at the falling edge, held while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
      if (!in_valid || samples_taken == words_sent) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data <= sample_backlog.pop_front();
          in_valid <= 1'b1;
          words_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Port monitor: check results, then predict from accepted samples
  always @(posedge clk) begin : watch_ports
    afac_pkg::out_word_t want;
    afac_pkg::out_word_t fresh;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (verdicts_due.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("Unexpected result word: level %0d kind %0d conf %0d short %0b ovf %0b",
                     out_data.alert_level, out_data.threat_kind,
                     out_data.confidence_pct, out_data.frame_short,
                     out_data.frame_overflow);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          kind_tally[want.threat_kind]++;
          if (want.frame_short) short_tally++;
          if (want.frame_overflow) overlong_tally++;
          if (want.alert_level == afac_pkg::LEVEL_AMBIENT) basic_hits++;
          if (out_data.alert_level !== want.alert_level ||
              out_data.threat_kind !== want.threat_kind ||
              out_data.confidence_pct !== want.confidence_pct ||
              out_data.frame_short !== want.frame_short ||
              out_data.frame_overflow !== want.frame_overflow) begin
            if (mismatches < MAX_REPORTS)
              $display({"Result %0d mismatch: expected level %0d kind %0d conf %0d ",
                        "short %0b ovf %0b, got level %0d kind %0d conf %0d ",
                        "short %0b ovf %0b"},
                       results_checked, want.alert_level, want.threat_kind,
                       want.confidence_pct, want.frame_short, want.frame_overflow,
                       out_data.alert_level, out_data.threat_kind,
                       out_data.confidence_pct, out_data.frame_short,
                       out_data.frame_overflow);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        samples_taken++;
        if (classify_sample(in_data, fresh)) verdicts_due.push_back(fresh);
      end
    end
  end

  function automatic void push_word(int v, bit last);
    afac_pkg::in_word_t w;
    w.sample = v[15:0];
    w.last_in_frame = last;
    sample_backlog.push_back(w);
  endfunction

  // Queues one frame of shaped audio; an open frame gets no last flag
  task automatic queue_frame(int len, frame_style_t style, bit closed);
    int           amp;
    int           base;
    int           v;
    frame_style_t pick;
    amp = $urandom_range(3000, 15000);
    base = $urandom_range(28000, 32767);
    if ($urandom_range(0, 1)) base = -base;
    for (int i = 0; i < len; i++) begin
      pick = (style == STYLE_MIX) ? frame_style_t'($urandom_range(0, 4)) : style;
      case (pick)
        STYLE_NOISE: v = $urandom_range(0, 65535) - 32768;
        STYLE_BUZZ:  v = ((i % 2) ? amp : 0) + $urandom_range(0, 400) - 200;
        STYLE_LOUD:  v = base + $urandom_range(0, 1600) - 800;
        STYLE_QUIET: v = $urandom_range(0, 600) - 300;
        default:     v = ($urandom_range(0, 9) == 0) ? base : 0;
      endcase
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      push_word(v, closed && i == len - 1);
    end
  endtask

  // Register write on the falling edge; the classifier copy follows it
  task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      afac_pkg::CFG_MODE:  cur_cfg.analysis_mode = value[0];
      afac_pkg::CFG_JUMP:  cur_cfg.jump_threshold = value[15:0];
      afac_pkg::CFG_CURVE: cur_cfg.curvature_threshold = value;
      afac_pkg::CFG_LOUD:  cur_cfg.loud_threshold = value[15:0];
      afac_pkg::CFG_PEAK:  cur_cfg.peak_threshold = value[15:0];
      default: ;
    endcase
  endtask

  // Mode and all thresholds: zero, all ones, reset value or a useful random level
  task automatic pick_settings();
    logic [DW-1:0] v;
    write_reg(afac_pkg::CFG_MODE, DW'($urandom));
    for (int r = int'(afac_pkg::CFG_JUMP); r <= int'(afac_pkg::CFG_PEAK); r++) begin
      case ($urandom_range(0, 9))
        0: v = '0;
        1: v = '1;
        2, 3: begin
          case (r)
            afac_pkg::CFG_JUMP:  v = DW'(afac_pkg::JUMP_RST);
            afac_pkg::CFG_CURVE: v = DW'(afac_pkg::CURVE_RST);
            afac_pkg::CFG_LOUD:  v = DW'(afac_pkg::LOUD_RST);
            default:             v = DW'(afac_pkg::PEAK_RST);
          endcase
        end
        default: v = DW'($urandom_range(2000, 32768));
      endcase
      // upper data bit is dropped by the 16-bit registers
      if (r != int'(afac_pkg::CFG_CURVE)) v[16] = $urandom_range(0, 1);
      write_reg(IW'(r), v);
    end
  endtask

  // Block is idle once every word is in, every verdict out and the pipe is flushed
  task automatic drain_and_wait();
    while (sample_backlog.size() != 0 || samples_taken != words_sent ||
           verdicts_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int           items_queued;
    int           len;
    int           phase;
    frame_style_t style;
    bit           frame_open;
    items_queued = 0;
    phase = 0;
    frame_open = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings, full-scale swings, one-sample frames, bit patterns
    push_word(32767, 1'b0);
    push_word(-32768, 1'b1);
    push_word(-32768, 1'b1);
    push_word(0, 1'b1);
    push_word(16'h5555, 1'b0);
    push_word(-21846, 1'b0);
    push_word(1, 1'b0);
    push_word(-1, 1'b0);
    push_word(0, 1'b1);
    drain_and_wait();
    // basic rule, plus writes to indexes that hold no register
    write_reg(afac_pkg::CFG_MODE, '0);
    write_reg(IW'(int'(afac_pkg::CFG_PEAK) + 1 + $urandom_range(0, 2)), '1);
    push_word(32767, 1'b0);
    push_word(-32768, 1'b0);
    push_word(0, 1'b0);
    push_word(1, 1'b1);
    push_word(-1, 1'b1);
    drain_and_wait();
    write_reg(afac_pkg::CFG_MODE, DW'(1));

    // Random phases; some leave a frame open across the next settings change
    while (items_queued < ITEM_TARGET || results_checked < RESULT_TARGET) begin
      idle_pct = (phase >= 4 && phase < 7) ? 0 : 37;
      if (phase > 0) pick_settings();
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, 31);
          1:       len = ($urandom_range(0, 1) ? 32 : 64) + $urandom_range(0, 2) - 1;
          default: len = $urandom_range(32, 100);
        endcase
        style = frame_style_t'($urandom_range(0, 5));
        queue_frame(len, style, 1'b1);
        items_queued += len;
      end
      frame_open = ($urandom_range(0, 3) == 0);
      if (frame_open) begin
        len = $urandom_range(1, 40);
        queue_frame(len, frame_style_t'($urandom_range(0, 5)), 1'b0);
        items_queued += len;
      end
      drain_and_wait();
      phase++;
    end
    if (frame_open) begin
      queue_frame(40, STYLE_LOUD, 1'b1);
      drain_and_wait();
    end

    $display("Covered %0d samples, %0d verdicts: %0d clear, %0d beacon, %0d laser, %0d recording",
             samples_taken, results_checked, kind_tally[afac_pkg::KIND_NONE],
             kind_tally[afac_pkg::KIND_BEACON], kind_tally[afac_pkg::KIND_LASER],
             kind_tally[afac_pkg::KIND_RECORDING]);
    $display("Too-short frames %0d, overlong frames %0d, basic-rule hits %0d, mismatches %0d",
             short_tally, overlong_tally, basic_hits, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout: %0d words queued, %0d verdicts outstanding",
             sample_backlog.size(), verdicts_due.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/afac_pkg.sv
design/afac_front.sv
design/afac_queue.sv
design/afac_back.sv
design/audio_frame_anomaly_classifier_top.sv
verif/tb_audio_frame_anomaly_classifier_top.sv
